// ===== sv/u8u2_pkg.sv =====
// u8u2_pkg: widths, byte classification masks and phase codes for the
// utf-8 to 16-bit code unit decoder; no dependencies
package u8u2_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int COUNT_W = 16;
    localparam int PHASE_W = 2;

    localparam logic [COUNT_W-1:0] MAX_UNITS_RESET = 16'hffff;

    // continuation bytes still expected
    localparam logic [PHASE_W-1:0] PHASE_LEAD     = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_ONE_LEFT = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_TWO_LEFT = 2'd2;

    localparam logic [BYTE_W-1:0] ASCII_MASK    = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK    = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD2_VALUE   = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK    = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD3_VALUE   = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD2_PAYLOAD = 8'h1f;
    localparam logic [BYTE_W-1:0] LEAD3_PAYLOAD = 8'h0f;
    localparam logic [BYTE_W-1:0] CONT_PAYLOAD  = 8'h3f;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              start_req;
    } byte_item_t;

    typedef struct packed {
        logic [UNIT_W-1:0]  code_unit;
        logic               finished;
        logic [COUNT_W-1:0] unit_count;
    } unit_item_t;

endpackage

// ===== sv/u8u2_byte_if.sv =====
// u8u2_byte_if: valid/ready channel carrying one utf-8 byte and its start flag
// depends on u8u2_pkg
interface u8u2_byte_if
    import u8u2_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    logic              start_req;

    modport source (output valid, output byte_in, output start_req, input ready);
    modport sink   (input valid, input byte_in, input start_req, output ready);
endinterface

// ===== sv/u8u2_unit_if.sv =====
// u8u2_unit_if: valid/ready channel carrying one decoded code unit result
// depends on u8u2_pkg
interface u8u2_unit_if
    import u8u2_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [UNIT_W-1:0]  code_unit;
    logic               finished;
    logic [COUNT_W-1:0] unit_count;

    modport source (output valid, output code_unit, output finished, output unit_count,
                    input ready);
    modport sink   (input valid, input code_unit, input finished, input unit_count,
                    output ready);
endinterface

// ===== sv/utf8_to_ucs2_decoder.sv =====
// utf8_to_ucs2_decoder: utf-8 byte stream to 16-bit basic plane code units
// depends on u8u2_pkg, u8u2_byte_if, u8u2_unit_if
//
// usage
//   byte_ch takes one utf-8 byte per transfer; start_req marks the first byte
//   of a string and clears count and phase before that byte is decoded.
//   unit_ch gives one result per completed code unit, and one final result
//   with finished set and code_unit zero when the string ends (null lead
//   byte, invalid or 4-byte lead, or a lead byte once max_units units are
//   out). bytes after the final result give nothing until the next start.
//   max_units_we/max_units_wdata write the unit limit; write it only while
//   the block is idle.
//   a result passes through the input register, then is decoded into the
//   output register, from which it is valid on unit_ch.
//   throughput: one byte per cycle while unit_ch does not stall; the decode
//   between the input register and the output register is combinational.
//   reset clears the phase, count and stopped flag and sets max_units to
//   65535; bytes without a start decode as a string begun at reset.
//   when unit_ch stalls, the output register holds its result and the input
//   register holds at most one more byte, after which byte_ch ready drops.
module utf8_to_ucs2_decoder
    import u8u2_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               max_units_we,
    input  logic [COUNT_W-1:0] max_units_wdata,
    u8u2_byte_if.sink          byte_ch,
    u8u2_unit_if.source        unit_ch
);

    logic [COUNT_W-1:0] max_units_reg;

    logic               in_valid_reg;
    byte_item_t         in_item_reg;

    logic [PHASE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [UNIT_W-1:0]  partial_reg, partial_next;
    logic [COUNT_W-1:0] units_reg, units_next;
    logic               stopped_reg, stopped_next;

    logic               out_valid_reg;
    unit_item_t         out_item_reg;

    logic               advance;
    logic               process;
    logic               emit;
    unit_item_t         result;

    // effective state after an optional start
    logic [PHASE_W-1:0] cur_left;
    logic [UNIT_W-1:0]  cur_partial;
    logic [COUNT_W-1:0] cur_units;
    logic               cur_stopped;
    logic [BYTE_W-1:0]  b;

    assign advance       = !out_valid_reg || unit_ch.ready;
    assign process       = in_valid_reg && advance;
    assign byte_ch.ready = !in_valid_reg || advance;

    assign unit_ch.valid      = out_valid_reg;
    assign unit_ch.code_unit  = out_item_reg.code_unit;
    assign unit_ch.finished   = out_item_reg.finished;
    assign unit_ch.unit_count = out_item_reg.unit_count;

    always_comb
    begin
        b           = in_item_reg.byte_in;
        cur_left    = in_item_reg.start_req ? PHASE_LEAD : bytes_left_reg;
        cur_partial = in_item_reg.start_req ? '0 : partial_reg;
        cur_units   = in_item_reg.start_req ? '0 : units_reg;
        cur_stopped = in_item_reg.start_req ? 1'b0 : stopped_reg;

        bytes_left_next = cur_left;
        partial_next    = cur_partial;
        units_next      = cur_units;
        stopped_next    = cur_stopped;
        emit            = 1'b0;
        result          = '{code_unit: '0, finished: 1'b0, unit_count: cur_units};

        if (!cur_stopped)
        begin
            unique case (cur_left)
                PHASE_LEAD:
                begin
                    priority if (b == '0 || cur_units >= max_units_reg)
                    begin
                        stopped_next = 1'b1;
                        emit         = 1'b1;
                        result       = '{code_unit: '0, finished: 1'b1,
                                         unit_count: cur_units};
                    end
                    else if ((b & ASCII_MASK) == '0)
                    begin
                        units_next = cur_units + 1'b1;
                        emit       = 1'b1;
                        result     = '{code_unit: {{(UNIT_W-BYTE_W){1'b0}}, b},
                                       finished: 1'b0, unit_count: units_next};
                    end
                    else if ((b & LEAD2_MASK) == LEAD2_VALUE)
                    begin
                        partial_next    = {5'b0, b[4:0] & LEAD2_PAYLOAD[4:0], 6'b0};
                        bytes_left_next = PHASE_ONE_LEFT;
                    end
                    else if ((b & LEAD3_MASK) == LEAD3_VALUE)
                    begin
                        partial_next    = {b[3:0] & LEAD3_PAYLOAD[3:0], 12'b0};
                        bytes_left_next = PHASE_TWO_LEFT;
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                        emit         = 1'b1;
                        result       = '{code_unit: '0, finished: 1'b1,
                                         unit_count: cur_units};
                    end
                end
                PHASE_TWO_LEFT:
                begin
                    partial_next    = cur_partial | {4'b0, b[5:0] & CONT_PAYLOAD[5:0], 6'b0};
                    bytes_left_next = PHASE_ONE_LEFT;
                end
                default:
                begin
                    // last continuation byte; an unreachable phase of 3 lands here too
                    bytes_left_next = PHASE_LEAD;
                    partial_next    = '0;
                    units_next      = cur_units + 1'b1;
                    emit            = 1'b1;
                    result          = '{code_unit: cur_partial |
                                                   {10'b0, b[5:0] & CONT_PAYLOAD[5:0]},
                                        finished: 1'b0, unit_count: units_next};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_units_reg  <= MAX_UNITS_RESET;
            in_valid_reg   <= 1'b0;
            bytes_left_reg <= PHASE_LEAD;
            partial_reg    <= '0;
            units_reg      <= '0;
            stopped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (max_units_we)
            begin
                max_units_reg <= max_units_wdata;
            end
            if (byte_ch.ready)
            begin
                in_valid_reg <= byte_ch.valid;
            end
            if (process)
            begin
                bytes_left_reg <= bytes_left_next;
                partial_reg    <= partial_next;
                units_reg      <= units_next;
                stopped_reg    <= stopped_next;
            end
            if (advance)
            begin
                out_valid_reg <= process && emit;
            end
        end
    end

    // payload registers, loaded on transfer
    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            in_item_reg <= '{byte_in: byte_ch.byte_in, start_req: byte_ch.start_req};
        end
        if (process && emit)
        begin
            out_item_reg <= result;
        end
    end

endmodule

// ===== sv/u8u2_checker.sv =====
// u8u2_checker: port-level assertions for utf8_to_ucs2_decoder, bound to it
// depends on u8u2_pkg
module u8u2_checker
    import u8u2_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               unit_valid,
    input logic               unit_ready,
    input logic [UNIT_W-1:0]  unit_code,
    input logic               unit_finished,
    input logic [COUNT_W-1:0] unit_count
);

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && !unit_ready |=> unit_valid)
        else $error("result dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && !unit_ready |=>
            $stable(unit_code) && $stable(unit_finished) && $stable(unit_count))
        else $error("result changed while stalled");

    a_final_zero: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && unit_finished |-> unit_code == '0)
        else $error("final result carries a code unit");

    a_unit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && !unit_finished |-> unit_count != '0)
        else $error("code unit with zero count");

endmodule

bind utf8_to_ucs2_decoder u8u2_checker u_u8u2_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .unit_valid    (unit_ch.valid),
    .unit_ready    (unit_ch.ready),
    .unit_code     (unit_ch.code_unit),
    .unit_finished (unit_ch.finished),
    .unit_count    (unit_ch.unit_count)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: random and directed stimulus for utf8_to_ucs2_decoder, checked by a
// scoreboard that decodes the same byte stream and compares every result
// depends on u8u2_pkg, u8u2_byte_if, u8u2_unit_if and utf8_to_ucs2_decoder
module testbench;
    import u8u2_pkg::*;

    class unit_scoreboard;
        logic [COUNT_W-1:0] limit;
        logic [PHASE_W-1:0] left;
        logic [UNIT_W-1:0]  partial;
        logic [COUNT_W-1:0] done;
        bit                 halted;
        unit_item_t         units_due[$];
        int                 errors;
        int                 checked;
        int                 strings_ended;

        function new();
            limit = MAX_UNITS_RESET;
            left = PHASE_LEAD;
            partial = '0;
            done = '0;
            halted = 0;
            errors = 0;
            checked = 0;
            strings_ended = 0;
        endfunction

        function void add_unit(logic [UNIT_W-1:0] code, logic fin);
            unit_item_t u;
            u.code_unit = code;
            u.finished = fin;
            u.unit_count = done;
            units_due.insert(units_due.size(), u);
        endfunction

        // returns 1 when the byte was decoded, 0 when the string had already ended
        function bit note_byte(logic [BYTE_W-1:0] b, logic s);
            if (s)
            begin
                left = PHASE_LEAD;
                partial = '0;
                done = '0;
                halted = 0;
            end
            if (halted)
                return 0;
            if (left == PHASE_LEAD)
            begin
                if (b == '0 || done >= limit)
                begin
                    halted = 1;
                    add_unit('0, 1'b1);
                end
                else if ((b & ASCII_MASK) == '0)
                begin
                    done = done + 1'b1;
                    add_unit(UNIT_W'(b), 1'b0);
                end
                else if ((b & LEAD2_MASK) == LEAD2_VALUE)
                begin
                    partial = UNIT_W'(b & LEAD2_PAYLOAD) << 6;
                    left = PHASE_ONE_LEFT;
                end
                else if ((b & LEAD3_MASK) == LEAD3_VALUE)
                begin
                    partial = UNIT_W'(b & LEAD3_PAYLOAD) << 12;
                    left = PHASE_TWO_LEFT;
                end
                else
                begin
                    halted = 1;
                    add_unit('0, 1'b1);
                end
            end
            else if (left == PHASE_TWO_LEFT)
            begin
                partial = partial | (UNIT_W'(b & CONT_PAYLOAD) << 6);
                left = PHASE_ONE_LEFT;
            end
            else
            begin
                // any other phase finishes the unit
                done = done + 1'b1;
                add_unit(partial | UNIT_W'(b & CONT_PAYLOAD), 1'b0);
                left = PHASE_LEAD;
                partial = '0;
            end
            return 1;
        endfunction

        function void check_unit(unit_item_t got);
            unit_item_t want;
            if (units_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result code_unit %h finished %b unit_count %0d",
                         $time, got.code_unit, got.finished, got.unit_count);
                return;
            end
            want = units_due.pop_front();
            checked++;
            if (want.finished)
                strings_ended++;
            if (want !== got)
            begin
                errors++;
                $display("%0t: mismatch expected code_unit %h finished %b unit_count %0d",
                         $time, want.code_unit, want.finished, want.unit_count);
                $display("%0t:          actual   code_unit %h finished %b unit_count %0d",
                         $time, got.code_unit, got.finished, got.unit_count);
            end
        endfunction

        function int pending();
            return units_due.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               max_units_we;
    logic [COUNT_W-1:0] max_units_wdata;

    u8u2_byte_if byte_ch();
    u8u2_unit_if unit_ch();

    utf8_to_ucs2_decoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_units_we    (max_units_we),
        .max_units_wdata (max_units_wdata),
        .byte_ch         (byte_ch),
        .unit_ch         (unit_ch)
    );

    unit_scoreboard sb = new();
    bit             quiet = 0;
    int             decoded_bytes = 0;
    int             sent_bytes = 0;
    int             stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // result side: check each transfer, stall at random
    initial
    begin
        unit_item_t got;
        unit_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && unit_ch.valid && unit_ch.ready)
            begin
                got.code_unit = unit_ch.code_unit;
                got.finished = unit_ch.finished;
                got.unit_count = unit_ch.unit_count;
                sb.check_unit(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                unit_ch.ready <= 1'b0;
            end
            else
            begin
                unit_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(5) == 0)
                    stall_left = gap_len();
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s);
        int n;
        n = quiet ? 0 : gap_len();
        if (n > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.byte_in <= b;
        byte_ch.start_req <= s;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        sent_bytes++;
        if (sb.note_byte(b, s))
            decoded_bytes++;
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // a byte that gives no result may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] v);
        drain();
        max_units_we <= 1'b1;
        max_units_wdata <= v;
        @(posedge clk);
        max_units_we <= 1'b0;
        sb.limit = v;
    endtask

    function automatic logic [BYTE_W-1:0] cont_byte();
        if ($urandom_range(9) == 0)
            return BYTE_W'($urandom);
        return {2'b10, 6'($urandom)};
    endfunction

    // one string of random characters and a random ending
    task automatic send_string();
        logic [BYTE_W-1:0] seq[$];
        int                n;
        int                r;
        n = $urandom_range(12);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(3);
            if (r < 2)
                seq.insert(seq.size(), BYTE_W'($urandom_range(127, 1)));
            else if (r == 2)
            begin
                seq.insert(seq.size(), {3'b110, 5'($urandom)});
                seq.insert(seq.size(), cont_byte());
            end
            else
            begin
                seq.insert(seq.size(), {4'b1110, 4'($urandom)});
                seq.insert(seq.size(), cont_byte());
                seq.insert(seq.size(), cont_byte());
            end
        end
        // cut inside a sequence now and then; the next start interrupts it
        if (seq.size() > 1 && $urandom_range(9) == 0)
            void'(seq.pop_back());
        r = $urandom_range(9);
        if (r < 4)
            seq.insert(seq.size(), BYTE_W'(0));
        else if (r < 6)
            seq.insert(seq.size(),
                       $urandom_range(1) ? {2'b10, 6'($urandom)} : {4'b1111, 4'($urandom)});
        else if (r == 6)
        begin
            seq.insert(seq.size(), BYTE_W'(0));
            repeat ($urandom_range(3, 1)) seq.insert(seq.size(), BYTE_W'($urandom));
        end
        if (seq.size() == 0)
            seq.insert(seq.size(), BYTE_W'($urandom));
        foreach (seq[i])
            send_byte(seq[i], i == 0);
    endtask

    initial
    begin
        logic [COUNT_W-1:0] limits[7];
        int                 goal;

        rst_n = 1'b0;
        max_units_we <= 1'b0;
        max_units_wdata <= '0;
        byte_ch.valid <= 1'b0;
        byte_ch.byte_in <= '0;
        byte_ch.start_req <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no start after reset, range extremes, unchecked continuations
        send_byte(8'h41, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hc2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hdf, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hef, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'he0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hc0, 1'b0);
        send_byte(8'he2, 1'b0);
        // start in the middle of a sequence
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b0);
        // stray continuation, 4-byte lead and all-ones lead end the string
        send_byte(8'h80, 1'b1);
        send_byte(8'hf0, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'hc3, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);

        limits = '{16'hffff, 16'd0, 16'd1, 16'd2, 16'd3,
                   COUNT_W'($urandom_range(15, 4)), 16'hffff};
        goal = sent_bytes;
        foreach (limits[p])
        begin
            write_limit(limits[p]);
            quiet = (p == 4);
            goal += 250;
            while (sent_bytes < goal)
            begin
                if ($urandom_range(99) < 85)
                    send_string();
                else
                    repeat ($urandom_range(6, 1))
                        send_byte(BYTE_W'($urandom), $urandom_range(7) == 0);
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.errors += sb.pending();
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        $display("sent %0d bytes (%0d decoded) over %0d unit limits, checked %0d results",
                 sent_bytes, decoded_bytes, $size(limits), sb.checked);
        $display("%0d strings ended, %0d errors", sb.strings_ended, sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
